@@ src/lmbs_pkg.sv @@
// Shared types and constants for the LED matrix bit-plane row scanner.
// No dependencies; imported by the frame store, row formatter and top level.
`timescale 1ns / 1ps

package lmbs_pkg;

    localparam int FRAME_ROWS = 16;
    localparam int ROW_BYTES  = 2;
    localparam int MUX_GROUPS = 4;
    localparam int LANES      = FRAME_ROWS * ROW_BYTES / MUX_GROUPS;
    localparam int LANE_W     = $clog2(LANES);
    localparam int WORD_W     = 8 * LANES;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_PROJECTION = 2'd0,
        CFG_DWELL0     = 2'd1,
        CFG_DWELL1     = 2'd2,
        CFG_DWELL2     = 2'd3
    } cfg_index_t;

    localparam logic [7:0] DWELL0_RESET = 8'd3;
    localparam logic [7:0] DWELL1_RESET = 8'd4;
    localparam logic [7:0] DWELL2_RESET = 8'd22;

    // byte write into the frame store
    typedef struct packed {
        logic              en;
        logic [1:0]        plane;
        logic [1:0]        group;
        logic [LANE_W-1:0] lane;
        logic [7:0]        data;
    } fs_wr_t;

    // row group read from the frame store
    typedef struct packed {
        logic       en;
        logic [1:0] plane;
        logic [1:0] group;
    } fs_rd_t;

endpackage

@@ src/lmbs_frame_store.sv @@
// Frame store: one word per plane and row group, holding rows r, r+4, r+8, r+12.
// Byte-lane writes, registered word read, per-byte valid bits cleared at reset.
// Depends on lmbs_pkg.
`timescale 1ns / 1ps

module lmbs_frame_store
    import lmbs_pkg::*;
#(
    parameter int PLANES = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fs_wr_t            wr,
    input  fs_rd_t            rd,
    output logic [WORD_W-1:0] rdata
);

    localparam int DEPTH  = PLANES * MUX_GROUPS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [LANES-1:0]  vld_reg [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic [LANES-1:0]  rd_vld_reg;
    logic [3:0]        wr_full;
    logic [3:0]        rd_full;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;

    assign wr_full = {wr.plane, wr.group};
    assign rd_full = {rd.plane, rd.group};
    assign waddr   = wr_full[ADDR_W-1:0];
    assign raddr   = rd_full[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[waddr][8*wr.lane +: 8] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= '0;
            end
            rd_vld_reg <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[waddr][wr.lane] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_vld_reg <= vld_reg[raddr];
            end
        end
    end

    // blank any byte never written since reset
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            rdata[8*k +: 8] = rd_vld_reg[k] ? rd_data_reg[8*k +: 8] : 8'h00;
        end
    end

endmodule

@@ src/lmbs_row_format.sv @@
// Row formatter: interleaves the four rows of a group into eight shift bytes.
// Applies the two fixed bit shuffles and the byte order of the layout mode.
// Depends on lmbs_pkg.
`timescale 1ns / 1ps

module lmbs_row_format
    import lmbs_pkg::*;
(
    input  logic [WORD_W-1:0] word,
    input  logic              projection,
    output logic [63:0]       shift_bytes
);

    function automatic logic [15:0] shuffle_a(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] r;
        r = '0;
        for (int k = 0; k < 4; k++)
        begin
            r[7-2*k]  = a[k];
            r[15-2*k] = a[4+k];
            r[6-2*k]  = b[k];
            r[14-2*k] = b[4+k];
        end
        return r;
    endfunction

    function automatic logic [15:0] shuffle_b(input logic [7:0] a, input logic [7:0] b);
        logic [15:0] r;
        r = '0;
        for (int k = 0; k < 4; k++)
        begin
            r[1+2*k] = a[k];
            r[9+2*k] = a[4+k];
            r[2*k]   = b[k];
            r[8+2*k] = b[4+k];
        end
        return r;
    endfunction

    logic [7:0]  row0_h0, row0_h1, row1_h0, row1_h1;
    logic [7:0]  row2_h0, row2_h1, row3_h0, row3_h1;
    logic [15:0] u0, u1, l0, l1;

    assign row0_h0 = word[7:0];
    assign row0_h1 = word[15:8];
    assign row1_h0 = word[23:16];
    assign row1_h1 = word[31:24];
    assign row2_h0 = word[39:32];
    assign row2_h1 = word[47:40];
    assign row3_h0 = word[55:48];
    assign row3_h1 = word[63:56];

    always_comb
    begin
        if (projection)
        begin
            u0 = shuffle_b(row0_h0, row1_h0);
            u1 = shuffle_b(row0_h1, row1_h1);
            l0 = shuffle_a(row2_h0, row3_h0);
            l1 = shuffle_a(row2_h1, row3_h1);
            shift_bytes = {l1, l0, u0[7:0], u0[15:8], u1[7:0], u1[15:8]};
        end
        else
        begin
            u0 = shuffle_a(row0_h0, row1_h0);
            u1 = shuffle_a(row0_h1, row1_h1);
            l0 = shuffle_b(row2_h0, row3_h0);
            l1 = shuffle_b(row2_h1, row3_h1);
            shift_bytes = {l0[7:0], l0[15:8], l1[7:0], l1[15:8], u1, u0};
        end
    end

endmodule

@@ src/led_matrix_bitplane_row_scanner.sv @@
// Top level of the LED matrix bit-plane row scanner.
// Depends on lmbs_pkg, lmbs_frame_store and lmbs_row_format.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready): opcode 0 transfers one frame byte
//   (wr_plane, wr_row, wr_half, wr_data) and gives no result; a byte for a
//   plane at or beyond PLANES is dropped. Opcode 1 is a scan tick: advance
//   the plane counter, and the row group on plane wrap, then give one result.
//   Output channel (out_valid/out_ready): shift_bytes, row_line, dwell and
//   shown_plane for the new plane and row group.
//   Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 is the
//   projection layout bit, 1..3 the dwell values of planes 0..2.
//   Result path: a tick's result passes the registered frame store read and
//   then the result register before it is valid.
//   Throughput: one item per cycle while out_ready keeps the result moving, set by the single-word frame store read.
//   Reset: counters, config and valid registers go to their reset values at
//   once; the frame is blank through per-byte valid bits, no clearing pass.
//   Stall: with out_ready low the result holds, one more tick moves into the
//   read stage, and then in_ready drops until the result is taken.

module led_matrix_bitplane_row_scanner
    import lmbs_pkg::*;
#(
    parameter int PLANES = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [1:0]  wr_plane,
    input  logic [3:0]  wr_row,
    input  logic        wr_half,
    input  logic [7:0]  wr_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] shift_bytes,
    output logic [1:0]  row_line,
    output logic [7:0]  dwell,
    output logic [1:0]  shown_plane,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic        proj_reg;
    logic [7:0]  dwell0_reg, dwell1_reg, dwell2_reg;
    logic [1:0]  plane_reg, plane_next;
    logic [1:0]  row_reg, row_next;
    logic        s1_valid_reg;
    logic        s1_proj_reg;
    logic [1:0]  s1_row_reg;
    logic [1:0]  s1_plane_reg;
    logic [7:0]  s1_dwell_reg;
    logic        out_valid_reg;
    logic [63:0] shift_bytes_reg;
    logic [1:0]  row_line_reg;
    logic [7:0]  dwell_reg;
    logic [1:0]  shown_plane_reg;
    logic        in_xfer, tick_xfer, s1_adv;
    logic [7:0]  dwell_sel;
    logic [WORD_W-1:0] rd_word;
    logic [63:0] fmt_bytes;
    fs_wr_t      fs_wr;
    fs_rd_t      fs_rd;

    assign cfg_ready = 1'b1;
    assign s1_adv    = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_xfer   = in_valid && in_ready;
    assign tick_xfer = in_xfer && (opcode == OP_TICK);

    always_comb
    begin
        plane_next = plane_reg;
        row_next   = row_reg;
        if (tick_xfer)
        begin
            if (plane_reg >= 2'(PLANES - 1))
            begin
                plane_next = 2'd0;
                row_next   = row_reg + 2'd1;
            end
            else
            begin
                plane_next = plane_reg + 2'd1;
            end
        end
    end

    always_comb
    begin
        case (plane_next)
            2'd0:    dwell_sel = dwell0_reg;
            2'd1:    dwell_sel = dwell1_reg;
            default: dwell_sel = dwell2_reg;
        endcase
    end

    always_comb
    begin
        fs_wr.en    = in_xfer && (opcode == OP_WRITE) && (wr_plane < 2'(PLANES));
        fs_wr.plane = wr_plane;
        fs_wr.group = wr_row[1:0];
        fs_wr.lane  = {wr_row[3:2], wr_half};
        fs_wr.data  = wr_data;
        fs_rd.en    = tick_xfer;
        fs_rd.plane = plane_next;
        fs_rd.group = row_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proj_reg   <= 1'b0;
            dwell0_reg <= DWELL0_RESET;
            dwell1_reg <= DWELL1_RESET;
            dwell2_reg <= DWELL2_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PROJECTION: proj_reg   <= cfg_data[0];
                CFG_DWELL0:     dwell0_reg <= cfg_data;
                CFG_DWELL1:     dwell1_reg <= cfg_data;
                CFG_DWELL2:     dwell2_reg <= cfg_data;
                default:        proj_reg   <= proj_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg     <= 2'd0;
            row_reg       <= 2'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            plane_reg <= plane_next;
            row_reg   <= row_next;
            if (in_ready)
            begin
                s1_valid_reg <= tick_xfer;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            s1_proj_reg  <= proj_reg;
            s1_row_reg   <= row_next;
            s1_plane_reg <= plane_next;
            s1_dwell_reg <= dwell_sel;
        end
        if (s1_adv && s1_valid_reg)
        begin
            shift_bytes_reg <= fmt_bytes;
            row_line_reg    <= ~s1_row_reg;
            dwell_reg       <= s1_dwell_reg;
            shown_plane_reg <= s1_plane_reg;
        end
    end

    lmbs_frame_store #(
        .PLANES (PLANES)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fs_wr),
        .rd    (fs_rd),
        .rdata (rd_word)
    );

    lmbs_row_format u_format (
        .word        (rd_word),
        .projection  (s1_proj_reg),
        .shift_bytes (fmt_bytes)
    );

    assign out_valid   = out_valid_reg;
    assign shift_bytes = shift_bytes_reg;
    assign row_line    = row_line_reg;
    assign dwell       = dwell_reg;
    assign shown_plane = shown_plane_reg;

    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        plane_reg < 2'(PLANES))
        else $error("plane counter out of range");

    a_tick_loads: assert property (@(posedge clk) disable iff (!rst_n)
        tick_xfer |=> s1_valid_reg)
        else $error("tick transfer did not reach the read stage");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (opcode == OP_WRITE)) |=> !s1_valid_reg)
        else $error("frame write produced a result");

    a_out_plane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (shown_plane < 2'(PLANES)))
        else $error("result shows a plane out of range");

endmodule
